[hw/rtl/stlr_pkg.sv]
// ----------------------------------------------------------------------------
// stlr_pkg: shared types and constants for the sonar tank level relay
// Field widths, reset values, the microcode word layout and the control
// program that sequences the shared divider.
// ----------------------------------------------------------------------------
package stlr_pkg;

  // Field widths
  localparam int TICKS_W   = 16;
  localparam int COEF_W    = 16;
  localparam int PCT_W     = 8;
  localparam int DIST_W    = 23;
  localparam int LEVEL_W   = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 16;

  // Divider geometry: one quotient bit per step, MSB first
  localparam int SH_W      = 38;            // dividend / quotient shift register
  localparam int REM_W     = DIST_W;        // partial remainder
  localparam int Q1_W      = 31;            // distance quotient width
  localparam int Q1_STEPS  = 31;
  localparam int Q2_STEPS  = LEVEL_W;
  localparam int CNT_W     = 5;
  localparam int PC_W      = 4;

  // Constants
  localparam logic [DIST_W-1:0]  DIST_MAX     = 23'd8388352;
  localparam logic [LEVEL_W-1:0] LEVEL_MAX    = 16'hFFFF;
  localparam logic [DIST_W-1:0]  HEIGHT_RESET = 23'd5120;
  localparam logic [COEF_W-1:0]  COEF_RESET   = 16'd18877;
  localparam logic [PCT_W-1:0]   LOW_RESET    = 8'd10;
  localparam logic [PCT_W-1:0]   HIGH_RESET   = 8'd90;
  localparam logic [14:0]        LEVEL_SCALE  = 15'd25600;  // 100 * 256

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TICKS_PER_UNIT = 2'd0,
    REG_LOW_LIMIT      = 2'd1,
    REG_HIGH_LIMIT     = 2'd2
  } reg_idx_t;

  // Datapath operations
  typedef enum logic [2:0] {
    OP_ACCEPT,     // take a transaction, load the distance division
    OP_DIV_STEP,   // one restoring divide step
    OP_DIST,       // saturate distance, apply store request
    OP_MUL,        // product = distance * 25600
    OP_LOAD2,      // load the level division
    OP_LEVEL_Q,    // take the level quotient
    OP_LEVEL_SAT,  // force the level to its maximum
    OP_EMIT        // update relay, load output register
  } op_t;

  // Hold conditions: the step repeats while the condition holds
  typedef enum logic [1:0] {
    W_NONE,
    W_INPUT,
    W_OUTPUT
  } wait_sel_t;

  // Jump conditions
  typedef enum logic [1:0] {
    J_NEVER,
    J_ALWAYS,
    J_MORE,
    J_SAT
  } jmp_sel_t;

  typedef logic [PC_W-1:0]  pc_t;
  typedef logic [CNT_W-1:0] cnt_t;

  // Step addresses
  localparam pc_t STEP_IDLE      = 4'd0;
  localparam pc_t STEP_DIV1      = 4'd1;
  localparam pc_t STEP_DIST      = 4'd2;
  localparam pc_t STEP_MUL       = 4'd3;
  localparam pc_t STEP_LOAD2     = 4'd4;
  localparam pc_t STEP_DIV2      = 4'd5;
  localparam pc_t STEP_LEVEL_Q   = 4'd6;
  localparam pc_t STEP_LEVEL_SAT = 4'd7;
  localparam pc_t STEP_EMIT      = 4'd8;

  typedef struct packed {
    op_t       op;
    wait_sel_t wait_sel;
    jmp_sel_t  jmp_sel;
    pc_t       target;
    logic      cnt_load;
    cnt_t      cnt_init;
  } ctrl_t;

  // Command from sequencer to datapath
  typedef struct packed {
    op_t  op;
    logic go;
  } cmd_t;

  // Status from datapath to sequencer
  typedef struct packed {
    logic in_valid;
    logic out_stall;
    logic level_sat;
  } status_t;

  // Control program
  function automatic ctrl_t ucode(input pc_t pc);
    ctrl_t w;
    w = '{op: OP_ACCEPT, wait_sel: W_NONE, jmp_sel: J_ALWAYS,
          target: STEP_IDLE, cnt_load: 1'b0, cnt_init: '0};
    case (pc)
      STEP_IDLE: begin
        w.op = OP_ACCEPT;  w.wait_sel = W_INPUT;  w.jmp_sel = J_NEVER;
        w.cnt_load = 1'b1; w.cnt_init = cnt_t'(Q1_STEPS - 1);
      end
      STEP_DIV1: begin
        w.op = OP_DIV_STEP; w.jmp_sel = J_MORE; w.target = STEP_DIV1;
      end
      STEP_DIST: begin
        w.op = OP_DIST; w.jmp_sel = J_NEVER;
      end
      STEP_MUL: begin
        w.op = OP_MUL; w.jmp_sel = J_NEVER;
      end
      STEP_LOAD2: begin
        w.op = OP_LOAD2; w.jmp_sel = J_SAT; w.target = STEP_LEVEL_SAT;
        w.cnt_load = 1'b1; w.cnt_init = cnt_t'(Q2_STEPS - 1);
      end
      STEP_DIV2: begin
        w.op = OP_DIV_STEP; w.jmp_sel = J_MORE; w.target = STEP_DIV2;
      end
      STEP_LEVEL_Q: begin
        w.op = OP_LEVEL_Q; w.jmp_sel = J_ALWAYS; w.target = STEP_EMIT;
      end
      STEP_LEVEL_SAT: begin
        w.op = OP_LEVEL_SAT; w.jmp_sel = J_NEVER;
      end
      STEP_EMIT: begin
        w.op = OP_EMIT; w.wait_sel = W_OUTPUT; w.jmp_sel = J_ALWAYS;
        w.target = STEP_IDLE;
      end
      default: begin
        w.op = OP_DIST; w.jmp_sel = J_ALWAYS; w.target = STEP_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

[hw/rtl/stlr_if.sv]
// ----------------------------------------------------------------------------
// stlr_if: streaming channels of the sonar tank level relay
// Echo measurement channel and result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface stlr_in_if;
  logic                        valid;
  logic                        ready;
  logic [stlr_pkg::TICKS_W-1:0] echo_ticks;
  logic                        store_request;

  modport source (output valid, echo_ticks, store_request, input ready);
  modport sink   (input valid, echo_ticks, store_request, output ready);
endinterface

interface stlr_out_if;
  logic                         valid;
  logic                         ready;
  logic [stlr_pkg::DIST_W-1:0]  distance_q8;
  logic [stlr_pkg::LEVEL_W-1:0] level_q8;
  logic [stlr_pkg::DIST_W-1:0]  height_q8;
  logic                         relay_on;

  modport source (output valid, distance_q8, level_q8, height_q8, relay_on, input ready);
  modport sink   (input valid, distance_q8, level_q8, height_q8, relay_on, output ready);
endinterface

[hw/rtl/stlr_sequencer.sv]
// ----------------------------------------------------------------------------
// stlr_sequencer: microcode sequencer
// Step counter, loop counter and control ROM; issues one command per cycle unless a wait condition holds the step.
// ----------------------------------------------------------------------------
module stlr_sequencer (
  input  logic              clk,
  input  logic              rst,
  input  stlr_pkg::status_t status,
  output stlr_pkg::cmd_t    cmd
);

  stlr_pkg::pc_t   pc;
  stlr_pkg::pc_t   pc_next;
  stlr_pkg::cnt_t  cnt;
  stlr_pkg::cnt_t  cnt_next;
  stlr_pkg::ctrl_t ctrl;
  logic            hold;
  logic            take_jump;

  // Fetch the control word
  assign ctrl = stlr_pkg::ucode(pc);

  // Decide hold, jump or advance
  always_comb begin
    case (ctrl.wait_sel)
      stlr_pkg::W_INPUT:  hold = !status.in_valid;
      stlr_pkg::W_OUTPUT: hold = status.out_stall;
      default:            hold = 1'b0;
    endcase
    case (ctrl.jmp_sel)
      stlr_pkg::J_ALWAYS: take_jump = 1'b1;
      stlr_pkg::J_MORE:   take_jump = (cnt != '0);
      stlr_pkg::J_SAT:    take_jump = status.level_sat;
      default:            take_jump = 1'b0;
    endcase
    if (hold) begin
      pc_next = pc;
    end else if (take_jump) begin
      pc_next = ctrl.target;
    end else begin
      pc_next = pc + stlr_pkg::pc_t'(1);
    end
    cnt_next = cnt;
    if (!hold && ctrl.cnt_load) begin
      cnt_next = ctrl.cnt_init;
    end else if (!hold && ctrl.jmp_sel == stlr_pkg::J_MORE) begin
      cnt_next = cnt - stlr_pkg::cnt_t'(1);
    end
    cmd.op = ctrl.op;
    cmd.go = !hold;
  end

  // Step and loop registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pc  <= stlr_pkg::STEP_IDLE;
      cnt <= '0;
    end else begin
      pc  <= pc_next;
      cnt <= cnt_next;
    end
  end

endmodule

[hw/rtl/stlr_datapath.sv]
// ----------------------------------------------------------------------------
// stlr_datapath: shared divider, multiplier and result registers
// Configuration registers, restoring divider, level product, relay state and
// the output register, all driven by sequencer commands.
// ----------------------------------------------------------------------------
module stlr_datapath (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_wr_en,
  input  logic [stlr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [stlr_pkg::CFG_DAT_W-1:0]  cfg_data,
  input  stlr_pkg::cmd_t                  cmd,
  output stlr_pkg::status_t               status,
  stlr_in_if.sink                         echo_in,
  stlr_out_if.source                      result_out
);

  // Configuration
  logic [stlr_pkg::COEF_W-1:0] ticks_per_unit;
  logic [stlr_pkg::PCT_W-1:0]  low_limit;
  logic [stlr_pkg::PCT_W-1:0]  high_limit;

  // Working registers
  logic [stlr_pkg::SH_W-1:0]    shreg;
  logic [stlr_pkg::REM_W-1:0]   rem;
  logic [stlr_pkg::DIST_W-1:0]  divisor;
  logic                         store;
  logic [stlr_pkg::DIST_W-1:0]  distance;
  logic [stlr_pkg::DIST_W-1:0]  height;
  logic [stlr_pkg::SH_W-1:0]    prod;
  logic [stlr_pkg::LEVEL_W-1:0] level;
  logic                         relay;

  // Output register
  logic                         out_valid;
  logic [stlr_pkg::DIST_W-1:0]  out_dist;
  logic [stlr_pkg::LEVEL_W-1:0] out_level;
  logic [stlr_pkg::DIST_W-1:0]  out_height;
  logic                         out_relay;

  logic [stlr_pkg::REM_W:0]     trial;
  logic                         fits;
  logic [stlr_pkg::REM_W:0]     trial_diff;
  logic [stlr_pkg::Q1_W-1:0]    quot1;
  logic [stlr_pkg::DIST_W-1:0]  dist_sat;
  logic [stlr_pkg::DIST_W-2:0]  prod_hi;
  logic                         relay_next;
  logic                         run;

  assign run = cmd.go;

  // Divide step: shift in the next dividend bit, subtract if it fits
  always_comb begin
    trial      = {rem, shreg[stlr_pkg::SH_W-1]};
    fits       = trial >= {1'b0, divisor};
    trial_diff = trial - {1'b0, divisor};
  end

  // Distance saturation and level overflow test
  always_comb begin
    quot1    = shreg[stlr_pkg::Q1_W-1:0];
    dist_sat = (quot1 > stlr_pkg::Q1_W'(stlr_pkg::DIST_MAX))
               ? stlr_pkg::DIST_MAX : quot1[stlr_pkg::DIST_W-1:0];
    prod_hi  = prod[stlr_pkg::SH_W-1:stlr_pkg::LEVEL_W];
  end

  // Hysteresis: on test first, off test wins
  always_comb begin
    relay_next = relay;
    if (level < {low_limit, 8'h00}) begin
      relay_next = 1'b1;
    end
    if (level > {high_limit, 8'h00}) begin
      relay_next = 1'b0;
    end
  end

  assign status.in_valid  = echo_in.valid;
  assign status.out_stall = out_valid && !result_out.ready;
  assign status.level_sat = (height == '0) || ({1'b0, prod_hi} >= height);

  assign echo_in.ready = (cmd.op == stlr_pkg::OP_ACCEPT);

  assign result_out.valid       = out_valid;
  assign result_out.distance_q8 = out_dist;
  assign result_out.level_q8    = out_level;
  assign result_out.height_q8   = out_height;
  assign result_out.relay_on    = out_relay;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      ticks_per_unit <= stlr_pkg::COEF_RESET;
      low_limit      <= stlr_pkg::LOW_RESET;
      high_limit     <= stlr_pkg::HIGH_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        stlr_pkg::REG_TICKS_PER_UNIT: ticks_per_unit <= cfg_data;
        stlr_pkg::REG_LOW_LIMIT:      low_limit      <= cfg_data[stlr_pkg::PCT_W-1:0];
        stlr_pkg::REG_HIGH_LIMIT:     high_limit     <= cfg_data[stlr_pkg::PCT_W-1:0];
        default: ;
      endcase
    end
  end

  // Kept state: tank height and relay
  always_ff @(posedge clk) begin
    if (rst) begin
      height <= stlr_pkg::HEIGHT_RESET;
      relay  <= 1'b0;
    end else if (run) begin
      if (cmd.op == stlr_pkg::OP_DIST && store) begin
        height <= dist_sat;
      end
      if (cmd.op == stlr_pkg::OP_EMIT) begin
        relay <= relay_next;
      end
    end
  end

  // Working datapath
  always_ff @(posedge clk) begin
    if (run) begin
      case (cmd.op)
        stlr_pkg::OP_ACCEPT: begin
          shreg   <= {echo_in.echo_ticks[stlr_pkg::TICKS_W-1:1],
                      (stlr_pkg::SH_W - stlr_pkg::TICKS_W + 1)'(0)};
          rem     <= '0;
          divisor <= stlr_pkg::DIST_W'(ticks_per_unit);
          store   <= echo_in.store_request;
        end
        stlr_pkg::OP_DIV_STEP: begin
          shreg <= {shreg[stlr_pkg::SH_W-2:0], fits};
          rem   <= fits ? trial_diff[stlr_pkg::REM_W-1:0] : trial[stlr_pkg::REM_W-1:0];
        end
        stlr_pkg::OP_DIST: begin
          distance <= dist_sat;
        end
        stlr_pkg::OP_MUL: begin
          prod <= {(stlr_pkg::SH_W - stlr_pkg::DIST_W)'(0), distance}
                  * stlr_pkg::SH_W'(stlr_pkg::LEVEL_SCALE);
        end
        stlr_pkg::OP_LOAD2: begin
          rem     <= {1'b0, prod_hi};
          shreg   <= {prod[stlr_pkg::LEVEL_W-1:0],
                      (stlr_pkg::SH_W - stlr_pkg::LEVEL_W)'(0)};
          divisor <= height;
        end
        stlr_pkg::OP_LEVEL_Q: begin
          level <= shreg[stlr_pkg::LEVEL_W-1:0];
        end
        stlr_pkg::OP_LEVEL_SAT: begin
          level <= stlr_pkg::LEVEL_MAX;
        end
        default: ;
      endcase
    end
  end

  // Output register: load on emit, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (run && cmd.op == stlr_pkg::OP_EMIT) begin
      out_valid <= 1'b1;
    end else if (result_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (run && cmd.op == stlr_pkg::OP_EMIT) begin
      out_dist   <= distance;
      out_level  <= level;
      out_height <= height;
      out_relay  <= relay_next;
    end
  end

endmodule

[hw/rtl/sonar_tank_level_relay_unit.sv]
// ----------------------------------------------------------------------------
// sonar_tank_level_relay_unit: sonar tank level with hysteresis relay
// Converts echo tick counts into distance and fill level and drives a pump
// relay between a low and a high level limit.
// ----------------------------------------------------------------------------
// Each echo transaction passes through the acceptance step, 31 divide steps
// for the distance, 16 divide steps for the level and five further control
// steps; its result is loaded into the output register in the last of them.
// When the level saturates (zero tank height or a level above full scale)
// the level division is skipped and the level is forced to full scale. The
// single restoring divider yields one quotient bit per cycle. One
// transaction is worked on at a time; the next one is accepted while the
// previous result still waits in the output register, and a waiting result
// stalls the final step. Configuration registers are written through
// cfg_wr_en, cfg_index and cfg_data and should only change while no
// transaction is in flight.
module sonar_tank_level_relay_unit (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_wr_en,
  input  logic [stlr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [stlr_pkg::CFG_DAT_W-1:0] cfg_data,
  stlr_in_if.sink                        echo_in,
  stlr_out_if.source                     result_out
);

  stlr_pkg::cmd_t    cmd;
  stlr_pkg::status_t status;

  // Control program
  stlr_sequencer u_seq (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .cmd    (cmd)
  );

  // Divider, multiplier and result registers
  stlr_datapath u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .cmd        (cmd),
    .status     (status),
    .echo_in    (echo_in),
    .result_out (result_out)
  );

endmodule

[hw/rtl/stlr_checker.sv]
// ----------------------------------------------------------------------------
// stlr_checker: port-level checks for the sonar tank level relay
// Watches both channels of the top level and flags broken behaviour.
// ----------------------------------------------------------------------------
module stlr_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [stlr_pkg::DIST_W-1:0]   distance_q8,
  input logic [stlr_pkg::LEVEL_W-1:0]  level_q8,
  input logic [stlr_pkg::DIST_W-1:0]   height_q8
);

  // No result straight out of reset
  a_reset_quiet: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  // One transaction at a time: intake closes after an accept
  a_single_item: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second transaction accepted while busy");

  // A stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid)
    else $error("result dropped while stalled");

  // Distance stays within its saturation limit
  a_dist_limit: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (distance_q8 <= stlr_pkg::DIST_MAX))
    else $error("distance above saturation limit");

  // Empty tank height forces full-scale level
  a_zero_height: assert property (@(posedge clk) disable iff (rst)
    (out_valid && height_q8 == '0) |-> (level_q8 == stlr_pkg::LEVEL_MAX))
    else $error("zero height without saturated level");

endmodule

bind sonar_tank_level_relay_unit stlr_checker u_chk (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (echo_in.valid),
  .in_ready    (echo_in.ready),
  .out_valid   (result_out.valid),
  .out_ready   (result_out.ready),
  .distance_q8 (result_out.distance_q8),
  .level_q8    (result_out.level_q8),
  .height_q8   (result_out.height_q8)
);

[dv/stlr_reading_checker.sv]
// ----------------------------------------------------------------------------
// stlr_reading_checker: level reading predictor and checker
// Watches the configuration port and both channels of the sonar tank level
// relay, predicts distance, level, tank height and relay state for every
// accepted echo transaction and compares each result transaction with the
// oldest pending prediction, field by field.
// ----------------------------------------------------------------------------
module stlr_reading_checker
  import stlr_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data,
  stlr_in_if                   echo_mon,
  stlr_out_if                  result_mon,
  output int unsigned          mismatches,
  output int unsigned          readings_due
);

  // 100 percent in Q8.8
  localparam logic [63:0] PERCENT_Q8 = 64'd25600;

  typedef struct packed {
    logic [DIST_W-1:0]  distance;
    logic [LEVEL_W-1:0] level;
    logic [DIST_W-1:0]  height;
    logic               relay;
  } reading_t;

  // Predicted block state and register copies
  logic [COEF_W-1:0] coef;
  logic [PCT_W-1:0]  low_pct;
  logic [PCT_W-1:0]  high_pct;
  logic [DIST_W-1:0] tank_height;
  logic              relay;

  reading_t    expected_readings[$];
  int unsigned fail_count = 0;

  initial begin
    mismatches   = 0;
    readings_due = 0;
  end

  // Halve the tick count and divide by the Q8.8 coefficient, saturating
  function automatic logic [DIST_W-1:0] echo_distance(input logic [TICKS_W-1:0] ticks,
                                                      input logic [COEF_W-1:0] c);
    logic [63:0] q;
    if (c == '0) return DIST_MAX;
    q = ({48'd0, ticks >> 1} << 16) / {48'd0, c};
    if (q > 64'(DIST_MAX)) return DIST_MAX;
    return q[DIST_W-1:0];
  endfunction

  // Level in Q8.8 percent; an empty tank height reads as full scale
  function automatic logic [LEVEL_W-1:0] fill_level(input logic [DIST_W-1:0] distance,
                                                    input logic [DIST_W-1:0] height);
    logic [63:0] q;
    if (height == '0) return LEVEL_MAX;
    q = (64'(distance) * PERCENT_Q8) / 64'(height);
    if (q > 64'(LEVEL_MAX)) return LEVEL_MAX;
    return q[LEVEL_W-1:0];
  endfunction

  // Advance the predicted state by one echo and return the reading it gives
  function automatic reading_t predict_reading(input logic [TICKS_W-1:0] ticks,
                                               input logic store);
    reading_t r;
    r.distance = echo_distance(ticks, coef);
    if (store) tank_height = r.distance;
    r.level = fill_level(r.distance, tank_height);
    // on test first, off test second: a level past both limits leaves the relay off
    if (32'(r.level) < (32'(low_pct) << 8)) relay = 1'b1;
    if (32'(r.level) > (32'(high_pct) << 8)) relay = 1'b0;
    r.height = tank_height;
    r.relay  = relay;
    return r;
  endfunction

  function automatic void check_field(input string field, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, actual %0d", field, want, got);
      fail_count++;
    end
  endfunction

  // Track configuration, queue predictions, compare results
  always @(posedge clk) begin
    reading_t want;
    reading_t got;
    if (rst) begin
      coef        = COEF_RESET;
      low_pct     = LOW_RESET;
      high_pct    = HIGH_RESET;
      tank_height = HEIGHT_RESET;
      relay       = 1'b0;
      expected_readings.delete();
    end else begin
      if (cfg_wr_en) begin
        case (reg_idx_t'(cfg_index))
          REG_TICKS_PER_UNIT: coef     = cfg_data[COEF_W-1:0];
          REG_LOW_LIMIT:      low_pct  = cfg_data[PCT_W-1:0];
          REG_HIGH_LIMIT:     high_pct = cfg_data[PCT_W-1:0];
          default: ;
        endcase
      end
      if (echo_mon.valid && echo_mon.ready)
        expected_readings.push_back(predict_reading(echo_mon.echo_ticks,
                                                    echo_mon.store_request));
      if (result_mon.valid && result_mon.ready) begin
        got.distance = result_mon.distance_q8;
        got.level    = result_mon.level_q8;
        got.height   = result_mon.height_q8;
        got.relay    = result_mon.relay_on;
        if (expected_readings.size() == 0) begin
          $error("reading: expected none, actual distance_q8 %0d level_q8 %0d",
                 got.distance, got.level);
          fail_count++;
        end else begin
          want = expected_readings.pop_front();
          check_field("distance_q8", 32'(want.distance), 32'(got.distance));
          check_field("level_q8",    32'(want.level),    32'(got.level));
          check_field("height_q8",   32'(want.height),   32'(got.height));
          check_field("relay_on",    32'(want.relay),    32'(got.relay));
        end
      end
    end
    mismatches   <= fail_count;
    readings_due <= unsigned'(expected_readings.size());
  end

endmodule

[dv/testbench.sv]
// ----------------------------------------------------------------------------
// testbench: sonar tank level relay unit
// Drives echo measurements and register settings into the unit, with random
// idling on both channels, a long result hold-off and drained pauses. The
// reading checker beside the unit predicts and compares every result.
// ----------------------------------------------------------------------------
module testbench;
  import stlr_pkg::*;

  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 250;
  localparam int HOLD_CYCLES = 400;

  logic                 clk;
  logic                 rst;
  logic                 cfg_wr_en;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DAT_W-1:0] cfg_data;

  bit          idle_on  = 1'b1;
  bit          hold_req = 1'b0;
  int unsigned stored_ticks;
  int unsigned mismatches;
  int unsigned readings_due;

  stlr_in_if  echo_if();
  stlr_out_if result_if();

  sonar_tank_level_relay_unit i_dut (
    .clk,
    .rst,
    .cfg_wr_en,
    .cfg_index,
    .cfg_data,
    .echo_in    (echo_if.sink),
    .result_out (result_if.source)
  );

  stlr_reading_checker i_checker (
    .clk,
    .rst,
    .cfg_wr_en,
    .cfg_index,
    .cfg_data,
    .echo_mon     (echo_if),
    .result_mon   (result_if),
    .mismatches   (mismatches),
    .readings_due (readings_due)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Guard against a hung run
  initial begin
    #15_000_000;
    $display("status: fail");
    $finish;
  end

  // Result side: random stalls, or a long hold-off when asked
  initial begin
    result_if.ready = 1'b0;
    @(negedge clk);
    forever begin
      if (hold_req) begin
        result_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        result_if.ready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(negedge clk);
      end else begin
        result_if.ready <= 1'b1;
        @(negedge clk);
      end
    end
  end

  // Offer one echo transaction and hold it until accepted
  task automatic send_echo(input logic [TICKS_W-1:0] ticks, input logic store);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      echo_if.valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk);
    end
    echo_if.valid         <= 1'b1;
    echo_if.echo_ticks    <= ticks;
    echo_if.store_request <= store;
    do @(posedge clk); while (!echo_if.ready);
    @(negedge clk);
  endtask

  // Stop offering and wait until every pending reading has come back
  task automatic drain;
    echo_if.valid <= 1'b0;
    do @(negedge clk); while (readings_due != 0);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [CFG_DAT_W-1:0] data);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
  endtask

  // Write all three registers; limit writes carry junk in the unused bits
  task automatic configure(input logic [COEF_W-1:0] coef, input logic [PCT_W-1:0] lo,
                           input logic [PCT_W-1:0] hi);
    write_reg(REG_TICKS_PER_UNIT, coef);
    write_reg(REG_LOW_LIMIT, {8'($urandom), lo});
    write_reg(REG_HIGH_LIMIT, {8'($urandom), hi});
    cfg_wr_en <= 1'b0;
  endtask

  task automatic phase_settings(input int p);
    int unsigned lo;
    case (p)
      0: configure(COEF_RESET, LOW_RESET, HIGH_RESET);
      1: configure(16'd256, 8'd0, 8'd255);
      2: configure(16'hFFFF, 8'd255, 8'd0);
      3: configure(16'd0, PCT_W'($urandom), PCT_W'($urandom));
      4: configure(16'd255, 8'd30, 8'd70);
      default: begin
        lo = $urandom_range(0, 60);
        configure(COEF_W'($urandom_range(256, 65535)), PCT_W'(lo),
                  PCT_W'(lo + $urandom_range(0, 60)));
      end
    endcase
  endtask

  // Mostly measurements scaled to the stored height, some stores and noise
  task automatic random_echo;
    int unsigned pick;
    int unsigned span;
    logic [TICKS_W-1:0] ticks;
    pick = $urandom_range(0, 99);
    if (pick < 6) begin
      if ($urandom_range(0, 7) == 0) ticks = TICKS_W'($urandom_range(0, 3));
      else ticks = TICKS_W'($urandom);
      stored_ticks = ticks;
      send_echo(ticks, 1'b1);
    end else if (pick < 85) begin
      span = stored_ticks + stored_ticks / 3 + 4;
      if (span > 65535) span = 65535;
      send_echo(TICKS_W'($urandom_range(0, span)), 1'b0);
    end else begin
      send_echo(TICKS_W'($urandom), 1'b0);
    end
  endtask

  initial begin
    rst                   = 1'b1;
    cfg_wr_en             = 1'b0;
    cfg_index             = REG_TICKS_PER_UNIT;
    cfg_data              = '0;
    echo_if.valid         = 1'b0;
    echo_if.echo_ticks    = '0;
    echo_if.store_request = 1'b0;
    repeat (9) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset settings: field extremes, hysteresis band, level overflow
    send_echo(16'd0, 1'b0);
    send_echo(16'd1, 1'b0);
    send_echo(16'd2, 1'b0);
    send_echo(16'd2950, 1'b0);
    send_echo(16'hFFFF, 1'b0);
    send_echo(16'hFFFE, 1'b0);
    send_echo(16'd295, 1'b0);
    send_echo(16'd1500, 1'b0);
    send_echo(16'hAAAA, 1'b0);
    send_echo(16'h5555, 1'b0);
    send_echo(16'd4000, 1'b1);
    send_echo(16'd400, 1'b0);
    send_echo(16'd3000, 1'b0);
    // zero tank height, then restore
    send_echo(16'd0, 1'b1);
    send_echo(16'd1234, 1'b0);
    send_echo(16'd1, 1'b1);
    send_echo(16'hFFFF, 1'b1);
    send_echo(16'd100, 1'b0);
    send_echo(16'd2950, 1'b1);
    send_echo(16'd250, 1'b0);

    // Zero coefficient saturates distance; crossed limits leave relay off
    drain;
    configure(16'd0, 8'd200, 8'd50);
    send_echo(16'd123, 1'b1);
    send_echo(16'hFFFF, 1'b0);
    send_echo(16'd0, 1'b0);
    stored_ticks = 65535;

    // Random phases over a range of settings
    for (int p = 0; p < PHASES; p++) begin
      drain;
      phase_settings(p);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (p == PHASES - 1 && n == PHASE_ITEMS / 2) idle_on = 1'b0;
        if (p == 1 && n == 40) hold_req = 1'b1;
        if (p == 4 && n == 120) drain;
        random_echo();
      end
    end

    drain;
    repeat (60) @(negedge clk);
    if (mismatches == 0 && readings_due == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
